// ===== hdl/intel_hex_record_loader_unit_assert.svh =====
// ----------------------------------------------------------------------------
// intel hex loader assertion macros
// shared concurrent check forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_LOADER_UNIT_ASSERT_SVH
`define INTEL_HEX_RECORD_LOADER_UNIT_ASSERT_SVH

// condition holds at every edge
`define IHEX_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent at the same edge
`define IHEX_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent at the next edge
`define IHEX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg
// types, codes and the character classifier of the intel hex loader
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ihex_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam logic [16:0] FLASH_SIZE_RESET = 17'h10000;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] TYPE_DATA  = 8'h00;
  localparam logic [7:0] TYPE_EOF   = 8'h01;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_BETWEEN,
    PH_COUNT,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_TYPE,
    PH_DATA,
    PH_CHECK
  } phase_t;

  typedef enum logic [1:0] {
    FIN_RUN,
    FIN_END,
    FIN_ERR
  } fin_t;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_END,
    KIND_ERROR
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NO_COLON,
    ERR_BAD_HEX,
    ERR_OUTSIDE,
    ERR_BAD_TYPE,
    ERR_CHECKSUM,
    ERR_NO_END
  } err_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
    logic       is_blank;
    logic       is_colon;
    logic       is_nul;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    logic [7:0]  d;
    r = '0;
    d = '0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      d = c - CHAR_0;
      r.is_hex = 1'b1;
      r.nibble = d[3:0];
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      d = c - CHAR_LA + 8'd10;
      r.is_hex = 1'b1;
      r.nibble = d[3:0];
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      d = c - CHAR_UA + 8'd10;
      r.is_hex = 1'b1;
      r.nibble = d[3:0];
    end
    r.is_blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    r.is_colon = (c == CHAR_COLON);
    r.is_nul   = (c == CHAR_NUL);
    return r;
  endfunction

endpackage

// ===== hdl/ihex_front.sv =====
// ----------------------------------------------------------------------------
// ihex_front
// accepts characters and registers their class for the record queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ihex_front
  import ihex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  character,
  output logic        push_valid,
  input  logic        push_ready,
  output char_class_t push_item
);

  logic        valid;
  char_class_t item;

  assign in_ready   = !valid || push_ready;
  assign push_valid = valid;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= classify(character);
    end
  end

endmodule

// ===== hdl/ihex_queue.sv =====
// ----------------------------------------------------------------------------
// ihex_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ihex_queue
  import ihex_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  char_class_t push_item,
  output logic        pop_valid,
  input  logic        pop_ready,
  output char_class_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  char_class_t   mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  `include "intel_hex_record_loader_unit_assert.svh"

  `IHEX_ASSERT_ALWAYS(a_count_range, count <= FULL, "queue count beyond depth")
  `IHEX_ASSERT_NEXT(a_count_step, push && !pop, count == $past(count) + 1'b1, "queue count lost a push")

endmodule

// ===== hdl/ihex_back.sv =====
// ----------------------------------------------------------------------------
// ihex_back
// record parser: runs the field sequence and registers at most one result per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ihex_back
  import ihex_pkg::*;
#(
  parameter logic [16:0] FLASH_RESET = FLASH_SIZE_RESET
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] flash_size,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  char_class_t pop_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] write_address,
  output logic [7:0]  write_data,
  output logic [2:0]  error_code,
  output logic [15:0] line_number
);

  logic [16:0] flash_limit;
  phase_t      phase, phase_next;
  fin_t        fin, fin_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic        pending, pending_next;
  logic [7:0]  cks, cks_next;
  logic [7:0]  left, left_next;
  logic [15:0] addr, addr_next;
  logic        is_end, is_end_next;
  logic [15:0] rec_count, rec_count_next;

  logic        emit;
  kind_t       res_kind;
  logic [15:0] res_addr;
  logic [7:0]  res_data;
  err_t        res_code;
  logic [7:0]  byte_val;
  logic [7:0]  sum;
  logic [16:0] rec_end;
  logic        pop;
  logic        out_valid_q;
  kind_t       kind_q;

  assign cfg_ready = 1'b1;
  assign pop_ready = !out_valid_q || out_ready;
  assign pop       = pop_valid && pop_ready;
  assign byte_val  = {high_nibble, pop_item.nibble};
  assign sum       = cks + byte_val;
  assign rec_end   = {1'b0, addr} + {9'b0, left};

  always_comb begin
    phase_next       = phase;
    fin_next         = fin;
    high_nibble_next = high_nibble;
    pending_next     = pending;
    cks_next         = cks;
    left_next        = left;
    addr_next        = addr;
    is_end_next      = is_end;
    rec_count_next   = rec_count;
    emit             = 1'b0;
    res_kind         = KIND_WRITE;
    res_addr         = '0;
    res_data         = '0;
    res_code         = ERR_NO_COLON;
    if (fin == FIN_RUN) begin
      if (phase == PH_FIRST || (phase == PH_BETWEEN && !pop_item.is_blank)) begin
        if (phase == PH_BETWEEN && pop_item.is_nul) begin
          emit     = 1'b1;
          res_kind = KIND_ERROR;
          res_code = ERR_NO_END;
          fin_next = FIN_ERR;
        end else begin
          if (rec_count != 16'hFFFF) begin
            rec_count_next = rec_count + 16'd1;
          end
          if (!pop_item.is_colon) begin
            emit     = 1'b1;
            res_kind = KIND_ERROR;
            res_code = ERR_NO_COLON;
            fin_next = FIN_ERR;
          end else begin
            cks_next     = '0;
            pending_next = 1'b0;
            is_end_next  = 1'b0;
            phase_next   = PH_COUNT;
          end
        end
      end else if (phase != PH_BETWEEN) begin
        if (!pop_item.is_hex) begin
          emit     = 1'b1;
          res_kind = KIND_ERROR;
          res_code = ERR_BAD_HEX;
          fin_next = FIN_ERR;
        end else if (!pending) begin
          high_nibble_next = pop_item.nibble;
          pending_next     = 1'b1;
        end else begin
          pending_next = 1'b0;
          case (phase)
            PH_COUNT: begin
              cks_next   = sum;
              left_next  = byte_val;
              phase_next = PH_ADDR_HI;
            end
            PH_ADDR_HI: begin
              cks_next   = sum;
              addr_next  = {byte_val, 8'h00};
              phase_next = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
              cks_next   = sum;
              addr_next  = {addr[15:8], byte_val};
              phase_next = PH_TYPE;
            end
            PH_TYPE: begin
              cks_next = sum;
              if (byte_val == TYPE_DATA) begin
                if (rec_end > flash_limit) begin
                  emit     = 1'b1;
                  res_kind = KIND_ERROR;
                  res_code = ERR_OUTSIDE;
                  fin_next = FIN_ERR;
                end else begin
                  phase_next = (left == 8'd0) ? PH_CHECK : PH_DATA;
                end
              end else if (byte_val == TYPE_EOF) begin
                is_end_next = 1'b1;
                phase_next  = PH_CHECK;
              end else begin
                emit     = 1'b1;
                res_kind = KIND_ERROR;
                res_code = ERR_BAD_TYPE;
                fin_next = FIN_ERR;
              end
            end
            PH_DATA: begin
              cks_next  = sum;
              addr_next = addr + 16'd1;
              left_next = left - 8'd1;
              if (left == 8'd1) begin
                phase_next = PH_CHECK;
              end
              emit     = 1'b1;
              res_kind = KIND_WRITE;
              res_addr = addr;
              res_data = byte_val;
            end
            PH_CHECK: begin
              if (sum != 8'd0) begin
                emit     = 1'b1;
                res_kind = KIND_ERROR;
                res_code = ERR_CHECKSUM;
                fin_next = FIN_ERR;
              end else if (is_end) begin
                emit     = 1'b1;
                res_kind = KIND_END;
                fin_next = FIN_END;
              end else begin
                phase_next = PH_BETWEEN;
              end
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_limit <= FLASH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      flash_limit <= flash_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FIRST;
      fin         <= FIN_RUN;
      high_nibble <= '0;
      pending     <= 1'b0;
      cks         <= '0;
      left        <= '0;
      addr        <= '0;
      is_end      <= 1'b0;
      rec_count   <= '0;
    end else if (pop) begin
      phase       <= phase_next;
      fin         <= fin_next;
      high_nibble <= high_nibble_next;
      pending     <= pending_next;
      cks         <= cks_next;
      left        <= left_next;
      addr        <= addr_next;
      is_end      <= is_end_next;
      rec_count   <= rec_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (pop_ready) begin
      out_valid_q <= pop && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      kind_q        <= res_kind;
      write_address <= res_addr;
      write_data    <= res_data;
      error_code    <= res_code;
      line_number   <= rec_count_next;
    end
  end

  assign out_valid = out_valid_q;
  assign kind      = kind_q;

  `include "intel_hex_record_loader_unit_assert.svh"

  `IHEX_ASSERT_NEXT(a_fin_sticky, fin != FIN_RUN, fin == $past(fin), "finish state changed")
  `IHEX_ASSERT_SAME(a_err_fin, out_valid_q && kind_q == KIND_ERROR, fin == FIN_ERR, "error item without error finish")
  `IHEX_ASSERT_SAME(a_end_fin, out_valid_q && kind_q == KIND_END, fin == FIN_END, "end item without end finish")
  `IHEX_ASSERT_NEXT(a_quiet_done, pop && fin != FIN_RUN, !out_valid_q, "item after finish")

endmodule

// ===== hdl/intel_hex_record_loader_unit.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_loader_unit
// intel hex text parser emitting flash byte writes, end and error items
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   character
//   cfg      sink       cfg_valid / cfg_ready flash_size
//   out      source     out_valid / out_ready kind, write_address, write_data,
//                                             error_code, line_number
//
// one character per cycle sustained while out is not stalled; a result passes
// from its character through the front register, queue and output register
// rst is synchronous; flash_size resets to 65536, parser to first record
// a stalled out channel fills the queue, then in_ready drops
// cfg writes are always taken: cfg_ready is high in every cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module intel_hex_record_loader_unit
  import ihex_pkg::*;
#(
  parameter int          QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter logic [16:0] FLASH_RESET = FLASH_SIZE_RESET
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] flash_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  character,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] write_address,
  output logic [7:0]  write_data,
  output logic [2:0]  error_code,
  output logic [15:0] line_number
);

  logic        push_valid;
  logic        push_ready;
  char_class_t push_item;
  logic        pop_valid;
  logic        pop_ready;
  char_class_t pop_item;

  ihex_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .character  (character),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  ihex_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  ihex_back #(
    .FLASH_RESET (FLASH_RESET)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .flash_size    (flash_size),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .write_address (write_address),
    .write_data    (write_data),
    .error_code    (error_code),
    .line_number   (line_number)
  );

endmodule

// ===== tb/sv/ihex_load_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_load_checker
// watches the character, config and result channels of the intel hex loader,
// tracks the record parse state per accepted character and compares every
// result item field by field against the oldest predicted one
// ----------------------------------------------------------------------------

module ihex_load_checker
  import ihex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [16:0] flash_size,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  character,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] write_address,
  input  logic [7:0]  write_data,
  input  logic [2:0]  error_code,
  input  logic [15:0] line_number,
  output int          mismatches,
  output int          pending
);

  typedef struct {
    kind_t       kind;
    logic [15:0] addr;
    logic [7:0]  data;
    err_t        code;
    logic [15:0] line;
  } load_result_t;

  load_result_t due_results[$];
  load_result_t head;
  int           errs = 0;

  phase_t      ph;
  fin_t        fin;
  logic [3:0]  hi_nib;
  logic        half;
  logic [7:0]  sum;
  logic [7:0]  left;
  logic [15:0] rec_addr;
  logic        end_rec;
  logic [15:0] rec_num;
  logic [16:0] flash_limit;

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      t = c - CHAR_0;
      return {1'b1, t[3:0]};
    end
    if (c >= CHAR_LA && c <= CHAR_LF) begin
      t = c - CHAR_LA + 8'd10;
      return {1'b1, t[3:0]};
    end
    if (c >= CHAR_UA && c <= CHAR_UF) begin
      t = c - CHAR_UA + 8'd10;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  task automatic post(input kind_t k, input logic [15:0] a, input logic [7:0] d,
                      input err_t e);
    load_result_t r;
    r.kind = k;
    r.addr = a;
    r.data = d;
    r.code = e;
    r.line = rec_num;
    due_results.push_back(r);
  endtask

  task automatic abort(input err_t e);
    fin = FIN_ERR;
    post(KIND_ERROR, 16'd0, 8'd0, e);
  endtask

  task automatic open_record(input logic [7:0] c);
    if (rec_num != 16'hFFFF) rec_num = rec_num + 16'd1;
    if (c != CHAR_COLON) begin
      abort(ERR_NO_COLON);
    end else begin
      sum = 8'd0;
      half = 1'b0;
      end_rec = 1'b0;
      ph = PH_COUNT;
    end
  endtask

  // one character of text; error code field is zero in write and end items
  task automatic track_char(input logic [7:0] c);
    logic [4:0]  dig;
    logic [7:0]  b;
    logic [7:0]  want;
    logic [16:0] reach;
    dig = digit_of(c);
    b = 8'd0;
    if (fin != FIN_RUN) begin
    end else if (ph == PH_FIRST) begin
      open_record(c);
    end else if (ph == PH_BETWEEN) begin
      if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
      end else if (c == CHAR_NUL) begin
        abort(ERR_NO_END);
      end else begin
        open_record(c);
      end
    end else if (!dig[4]) begin
      abort(ERR_BAD_HEX);
    end else if (!half) begin
      hi_nib = dig[3:0];
      half = 1'b1;
    end else begin
      half = 1'b0;
      b = {hi_nib, dig[3:0]};
      case (ph)
        PH_COUNT: begin
          sum = sum + b;
          left = b;
          ph = PH_ADDR_HI;
        end
        PH_ADDR_HI: begin
          sum = sum + b;
          rec_addr = {b, 8'd0};
          ph = PH_ADDR_LO;
        end
        PH_ADDR_LO: begin
          sum = sum + b;
          rec_addr = {rec_addr[15:8], b};
          ph = PH_TYPE;
        end
        PH_TYPE: begin
          sum = sum + b;
          if (b == TYPE_DATA) begin
            reach = {1'b0, rec_addr} + {9'd0, left};
            if (reach > flash_limit) abort(ERR_OUTSIDE);
            else ph = (left == 8'd0) ? PH_CHECK : PH_DATA;
          end else if (b == TYPE_EOF) begin
            end_rec = 1'b1;
            ph = PH_CHECK;
          end else begin
            abort(ERR_BAD_TYPE);
          end
        end
        PH_DATA: begin
          post(KIND_WRITE, rec_addr, b, ERR_NO_COLON);
          sum = sum + b;
          rec_addr = rec_addr + 16'd1;
          left = left - 8'd1;
          if (left == 8'd0) ph = PH_CHECK;
        end
        default: begin
          want = ~sum + 8'd1;
          if (b != want) begin
            abort(ERR_CHECKSUM);
          end else if (end_rec) begin
            fin = FIN_END;
            post(KIND_END, 16'd0, 8'd0, ERR_NO_COLON);
          end else begin
            ph = PH_BETWEEN;
          end
        end
      endcase
    end
  endtask

  task automatic report(input string what, input int want, input int got);
    $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
    errs++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ph = PH_FIRST;
      fin = FIN_RUN;
      hi_nib = 4'd0;
      half = 1'b0;
      sum = 8'd0;
      left = 8'd0;
      rec_addr = 16'd0;
      end_rec = 1'b0;
      rec_num = 16'd0;
      flash_limit = FLASH_SIZE_RESET;
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected item kind %0d addr %0h data %0h code %0d line %0d",
                   $time, kind, write_address, write_data, error_code, line_number);
          errs++;
        end else begin
          head = due_results.pop_front();
          if (kind !== head.kind) report("kind", head.kind, kind);
          if (write_address !== head.addr) report("write_address", head.addr, write_address);
          if (write_data !== head.data) report("write_data", head.data, write_data);
          if (error_code !== head.code) report("error_code", head.code, error_code);
          if (line_number !== head.line) report("line_number", head.line, line_number);
        end
      end
      if (cfg_valid && cfg_ready) flash_limit = flash_size;
      if (in_valid && in_ready) track_char(character);
    end
    pending <= due_results.size();
    mismatches <= errs;
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// streams intel hex text into the loader: a few directed records, then long
// runs of well-formed data records under several flash sizes, closed by one
// randomly chosen end record or error, then ignored trailing characters
// ----------------------------------------------------------------------------

module tb;
  import ihex_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int PHASE_ITEMS = 275;

  typedef enum int {
    CLOSE_EOF,
    CLOSE_JUNK,
    CLOSE_NUL,
    CLOSE_BAD_DIGIT,
    CLOSE_OUTSIDE,
    CLOSE_BAD_TYPE,
    CLOSE_BAD_SUM
  } closing_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] flash_size = 17'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  character = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [15:0] write_address;
  logic [7:0]  write_data;
  logic [2:0]  error_code;
  logic [15:0] line_number;

  int          mismatches;
  int          pending;
  int          sent = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  logic        quiet = 1'b0;
  int          flash_plan[6];
  logic [7:0]  blanks[6];
  logic [7:0]  rec_cnt;
  logic [15:0] rec_addr;
  logic [7:0]  junk;
  closing_t    closing;
  int          span_lo;

  always #6 clk = ~clk;

  intel_hex_record_loader_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .flash_size    (flash_size),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .character     (character),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .write_address (write_address),
    .write_data    (write_data),
    .error_code    (error_code),
    .line_number   (line_number)
  );

  ihex_load_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .flash_size    (flash_size),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .character     (character),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .write_address (write_address),
    .write_data    (write_data),
    .error_code    (error_code),
    .line_number   (line_number),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("[intel_hex_record_loader_unit] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CHAR_0 + n;
    return (($urandom_range(0, 1) == 1) ? CHAR_UA : CHAR_LA) + n - 8'd10;
  endfunction

  task automatic send_char(input logic [7:0] c);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    character <= c;
    sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_hex_byte(input logic [7:0] b);
    send_char(hex_char(b[7:4]));
    send_char(hex_char(b[3:0]));
  endtask

  task automatic send_gap();
    repeat ($urandom_range(0, 3)) send_char(blanks[$urandom_range(0, 5)]);
  endtask

  // spoil is xored into the checksum byte
  task automatic send_record(input logic [7:0] cnt, input logic [15:0] addr,
                             input logic [7:0] rtype, input logic [7:0] spoil);
    logic [7:0] sum;
    logic [7:0] d;
    sum = cnt + addr[15:8] + addr[7:0] + rtype;
    send_char(CHAR_COLON);
    send_hex_byte(cnt);
    send_hex_byte(addr[15:8]);
    send_hex_byte(addr[7:0]);
    send_hex_byte(rtype);
    if (rtype == TYPE_DATA) begin
      for (int i = 0; i < cnt; i++) begin
        d = 8'($urandom_range(0, 255));
        sum = sum + d;
        send_hex_byte(d);
      end
    end
    send_hex_byte((~sum + 8'd1) ^ spoil);
  endtask

  // count and address of a data record that fits below limit
  task automatic pick_span(input int limit, output logic [7:0] cnt,
                           output logic [15:0] addr);
    int r;
    int c;
    int top;
    r = $urandom_range(0, 19);
    if (r < 16) c = $urandom_range(0, 16);
    else if (r < 19) c = $urandom_range(17, 64);
    else c = $urandom_range(65, 255);
    if (c > limit) c = limit;
    top = limit - c;
    if (top > 65535) top = 65535;
    if ($urandom_range(0, 3) == 0) addr = 16'(top - $urandom_range(0, (top < 15) ? top : 15));
    else addr = 16'($urandom_range(0, top));
    cnt = 8'(c);
  endtask

  task automatic set_flash(input int v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    flash_size <= 17'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    blanks = '{CHAR_SPACE, CHAR_TAB, 8'h0A, 8'h0B, 8'h0C, CHAR_CR};
    flash_plan = '{$urandom_range(1, 65536), 0, 131071, 65536,
                   $urandom_range(1, 300), $urandom_range(256, 65000)};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_flash(65536);

    // top address and empty record, every blank kind between them
    send_record(8'd1, 16'hFFFF, TYPE_DATA, 8'd0);
    foreach (blanks[i]) send_char(blanks[i]);
    send_record(8'd0, 16'h0000, TYPE_DATA, 8'd0);

    foreach (flash_plan[p]) begin
      set_flash(flash_plan[p]);
      if (p == 5) quiet <= 1'b1;
      span_lo = sent + PHASE_ITEMS;
      while (sent < span_lo) begin
        send_gap();
        pick_span(flash_plan[p], rec_cnt, rec_addr);
        send_record(rec_cnt, rec_addr, TYPE_DATA, 8'd0);
      end
    end

    // one closing event, the loader stops there
    closing = closing_t'($urandom_range(0, 6));
    send_gap();
    case (closing)
      CLOSE_EOF: begin
        send_record(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), TYPE_EOF,
                    8'd0);
      end
      CLOSE_JUNK: begin
        do junk = 8'($urandom_range(0, 255));
        while (junk == CHAR_COLON || junk == CHAR_NUL || junk == CHAR_SPACE ||
               (junk >= CHAR_TAB && junk <= CHAR_CR));
        send_char(junk);
      end
      CLOSE_NUL: begin
        send_char(CHAR_NUL);
      end
      CLOSE_BAD_DIGIT: begin
        send_char(CHAR_COLON);
        repeat ($urandom_range(0, 7)) send_char(hex_char(4'($urandom_range(0, 15))));
        if ($urandom_range(0, 3) == 0) begin
          junk = CHAR_NUL;
        end else begin
          do junk = 8'($urandom_range(0, 255));
          while ((junk >= CHAR_0 && junk <= CHAR_9) || (junk >= CHAR_LA && junk <= CHAR_LF) ||
                 (junk >= CHAR_UA && junk <= CHAR_UF));
        end
        send_char(junk);
      end
      CLOSE_OUTSIDE: begin
        rec_cnt = 8'($urandom_range(1, 255));
        span_lo = (flash_plan[5] >= rec_cnt) ? flash_plan[5] - rec_cnt + 1 : 0;
        rec_addr = 16'(span_lo + $urandom_range(0, 200));
        send_record(rec_cnt, rec_addr, TYPE_DATA, 8'd0);
      end
      CLOSE_BAD_TYPE: begin
        send_record(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                    8'($urandom_range(2, 255)), 8'd0);
      end
      default: begin
        pick_span(flash_plan[5], rec_cnt, rec_addr);
        send_record(rec_cnt, rec_addr, TYPE_DATA, 8'($urandom_range(1, 255)));
      end
    endcase

    // trailing text is ignored once loading has stopped
    repeat (40) send_char(8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("[intel_hex_record_loader_unit] OK");
    end else begin
      $display("[intel_hex_record_loader_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ihex_pkg.sv
hdl/ihex_front.sv
hdl/ihex_queue.sv
hdl/ihex_back.sv
hdl/intel_hex_record_loader_unit.sv
tb/sv/ihex_load_checker.sv
tb/sv/tb.sv
